/* src/tvf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_pkg
// Shared types and constants for the TSDF voxel fusion block.
// ----------------------------------------------------------------------------
package tvf_pkg;

    localparam int MAP_VOXELS = 65536;
    localparam int MAP_AW     = $clog2(MAP_VOXELS);

    localparam int ADDR_W  = 16;
    localparam int DIST_W  = 16;
    localparam int WT_W    = 30;
    localparam int TRUNC_W = 15;
    localparam int EPS_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IW  = 1;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_TRUNC = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_EPS   = 1'd1;

    localparam logic [TRUNC_W-1:0] TRUNC_RESET = 15'd819;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd7;

    localparam logic signed [DIST_W-1:0] ONE_Q12    = 16'sd4096;
    localparam logic [WT_W-1:0]          WEIGHT_MAX = 30'd655360000;

    typedef struct packed {
        logic [ADDR_W-1:0]        addr;
        logic [MAP_AW-1:0]        idx;
        logic signed [DIST_W-1:0] distance;
        logic [WT_W-1:0]          wt;
    } tvf_entry_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic [WT_W-1:0]          wt;
    } tvf_word_t;

    typedef struct packed {
        logic clearing;
    } tvf_status_t;

    localparam tvf_word_t RESET_WORD = '{distance: ONE_Q12, wt: '0};

endpackage

/* src/tvf_sample_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_sample_if
// Input channel: one voxel observation per beat.
// ----------------------------------------------------------------------------
interface tvf_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [tvf_pkg::ADDR_W-1:0]           voxel_address;
    logic signed [tvf_pkg::DIST_W-1:0]    sample_distance;
    logic [tvf_pkg::WT_W-1:0]             sample_weight;

    modport source (output valid, voxel_address, sample_distance, sample_weight,
                    input ready);
    modport sink   (input valid, voxel_address, sample_distance, sample_weight,
                    output ready);
endinterface

/* src/tvf_update_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_update_if
// Output channel: one updated voxel per beat.
// ----------------------------------------------------------------------------
interface tvf_update_if;
    logic                                 valid;
    logic                                 ready;
    logic [tvf_pkg::ADDR_W-1:0]           updated_address;
    logic signed [tvf_pkg::DIST_W-1:0]    updated_distance;
    logic [tvf_pkg::WT_W-1:0]             updated_weight;
    logic                                 became_unknown;

    modport source (output valid, updated_address, updated_distance, updated_weight,
                    became_unknown, input ready);
    modport sink   (input valid, updated_address, updated_distance, updated_weight,
                    became_unknown, output ready);
endinterface

/* src/tvf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_front
// Accepts sample beats, maps the address onto the store and queues them
// in a two-entry FIFO for the update engine.
// ----------------------------------------------------------------------------
module tvf_front
(
    input  logic                clk,
    input  logic                rst_n,
    tvf_sample_if.sink          sample,
    input  tvf_pkg::tvf_status_t status,
    output logic                head_valid,
    output tvf_pkg::tvf_entry_t head,
    input  logic                pop
);

    tvf_pkg::tvf_entry_t fifo_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                push;
    tvf_pkg::tvf_entry_t entry;

    assign sample.ready = (count_reg != 2'd2) && !status.clearing;
    assign push         = sample.valid && sample.ready;

    always_comb
    begin
        entry.addr     = sample.voxel_address;
        entry.idx      = sample.voxel_address[tvf_pkg::MAP_AW-1:0];
        entry.distance = sample.sample_distance;
        entry.wt       = sample.sample_weight;
    end

    assign head_valid = (count_reg != 2'd0);
    assign head       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

/* src/tvf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_back
// Update engine: voxel store, read-modify-write with one shared multiplier,
// a radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
module tvf_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  tvf_pkg::tvf_entry_t                 head,
    output logic                                pop,
    input  logic [tvf_pkg::TRUNC_W-1:0]         trunc,
    input  logic [tvf_pkg::EPS_W-1:0]           eps,
    output tvf_pkg::tvf_status_t                status,
    tvf_update_if.source                        update
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_MULA = 4'd2;
    localparam logic [3:0] ST_MULB = 4'd3;
    localparam logic [3:0] ST_SUM  = 4'd4;
    localparam logic [3:0] ST_ABS  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam int NUM_W = 47;
    localparam int SUM_W = 31;
    localparam int QW    = 16;

    // Voxel store
    tvf_pkg::tvf_word_t          mem [tvf_pkg::MAP_VOXELS];
    tvf_pkg::tvf_word_t          rd_data_reg;
    logic                        mem_we;
    logic [tvf_pkg::MAP_AW-1:0]  mem_wa;
    tvf_pkg::tvf_word_t          mem_wd;

    logic                        clearing_reg, clearing_next;
    logic [tvf_pkg::MAP_AW-1:0]  clr_cnt_reg, clr_cnt_next;

    logic [3:0]                  state_reg, state_next;
    tvf_pkg::tvf_entry_t         item_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic                        unk_reg;
    logic                        zero_old_reg;
    logic signed [tvf_pkg::DIST_W-1:0] ov_reg;
    logic [tvf_pkg::WT_W-1:0]    ow_reg;
    logic signed [NUM_W-1:0]     acc_reg;
    logic signed [NUM_W-1:0]     prod_reg;
    logic                        neg_reg;
    logic [SUM_W-1:0]            rem_reg;
    logic [QW-1:0]               quo_reg;
    logic [3:0]                  cnt_reg;
    logic signed [tvf_pkg::DIST_W-1:0] q_reg;
    logic [tvf_pkg::WT_W-1:0]    sw_reg;

    logic                        out_valid_reg;
    logic [tvf_pkg::ADDR_W-1:0]  out_addr_reg;
    logic signed [tvf_pkg::DIST_W-1:0] out_dist_reg;
    logic [tvf_pkg::WT_W-1:0]    out_wt_reg;
    logic                        out_unk_reg;
    logic                        slot_free;

    logic [SUM_W-1:0]            sum;
    logic signed [tvf_pkg::DIST_W-1:0] mul_a;
    logic signed [SUM_W-1:0]     mul_b;
    logic signed [NUM_W-1:0]     mul_p;
    logic signed [NUM_W-1:0]     mag;
    logic [SUM_W:0]              trial;
    logic                        take;
    logic [QW-1:0]               qclamp;

    assign status.clearing = clearing_reg;
    assign slot_free       = !out_valid_reg || update.ready;
    assign pop             = (state_reg == ST_IDLE) && head_valid && !clearing_reg;

    // Datapath helpers
    assign sum = {1'b0, rd_data_reg.wt} + {1'b0, item_reg.wt};

    always_comb
    begin
        if (state_reg == ST_MULA)
        begin
            mul_a = zero_old_reg ? '0 : ov_reg;
            mul_b = $signed({1'b0, ow_reg});
        end
        else
        begin
            mul_a = item_reg.distance;
            mul_b = $signed({1'b0, item_reg.wt});
        end
    end
    assign mul_p = mul_a * mul_b;

    assign mag   = acc_reg[NUM_W-1] ? -acc_reg : acc_reg;
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign take  = trial >= {1'b0, sum_reg};

    assign qclamp = (quo_reg > {1'b0, trunc}) ? {1'b0, trunc} : quo_reg;

    // Store write port: clearing sweep or write-back
    always_comb
    begin
        mem_we = clearing_reg || ((state_reg == ST_DONE) && slot_free);
        mem_wa = clearing_reg ? clr_cnt_reg : item_reg.idx;
        mem_wd = clearing_reg ? tvf_pkg::RESET_WORD
                              : tvf_pkg::tvf_word_t'{distance: q_reg, wt: sw_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[head.idx];
    end

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (pop) state_next = ST_READ;
            ST_READ: state_next = ((sum < {15'd0, eps}) || (sum == '0)) ? ST_DONE : ST_MULA;
            ST_MULA: state_next = ST_MULB;
            ST_MULB: state_next = ST_SUM;
            ST_SUM:  state_next = ST_ABS;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:  if (&cnt_reg) state_next = ST_FIN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            if ((state_reg == ST_DONE) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (update.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        case (state_reg)
            ST_READ:
            begin
                sum_reg      <= sum;
                unk_reg      <= (sum < {15'd0, eps}) || (sum == '0);
                zero_old_reg <= rd_data_reg.wt < {14'd0, eps};
                ov_reg       <= rd_data_reg.distance;
                ow_reg       <= rd_data_reg.wt;
                // Unknown voxel: skip the arithmetic
                q_reg        <= tvf_pkg::ONE_Q12;
                sw_reg       <= '0;
            end
            ST_MULA: acc_reg  <= mul_p;
            ST_MULB: prod_reg <= mul_p;
            ST_SUM:  acc_reg  <= acc_reg + prod_reg;
            ST_ABS:
            begin
                neg_reg <= acc_reg[NUM_W-1];
                rem_reg <= mag[NUM_W-1:QW];
                quo_reg <= mag[QW-1:0];
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                // One quotient bit a cycle; the remainder stays below the divisor
                rem_reg <= take ? SUM_W'(trial - {1'b0, sum_reg}) : trial[SUM_W-1:0];
                quo_reg <= {quo_reg[QW-2:0], take};
                cnt_reg <= cnt_reg + 4'd1;
            end
            ST_FIN:
            begin
                q_reg  <= neg_reg ? -$signed(qclamp) : $signed(qclamp);
                sw_reg <= (sum_reg > {1'b0, tvf_pkg::WEIGHT_MAX}) ?
                          tvf_pkg::WEIGHT_MAX : sum_reg[tvf_pkg::WT_W-1:0];
            end
            default: ;
        endcase
        if ((state_reg == ST_DONE) && slot_free)
        begin
            out_addr_reg <= item_reg.addr;
            out_dist_reg <= q_reg;
            out_wt_reg   <= sw_reg;
            out_unk_reg  <= unk_reg;
        end
    end

    assign update.valid            = out_valid_reg;
    assign update.updated_address  = out_addr_reg;
    assign update.updated_distance = out_dist_reg;
    assign update.updated_weight   = out_wt_reg;
    assign update.became_unknown   = out_unk_reg;

endmodule

/* src/tsdf_voxel_fusion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf_voxel_fusion
// Weighted-average TSDF update of one voxel per sample beat.
//
// Each beat on 'sample' names a voxel and brings a Q4.12 distance and a
// Q14.16 weight; one beat on 'update' reports the fused voxel, in order.
// Configuration (truncation distance, weight epsilon) is written through
// cfg_write_enable / cfg_index / cfg_data; the user writes it only while
// the block is idle; the block does not enforce it. A two-entry queue in
// front of the update engine takes samples while the engine is busy;
// 'sample.ready' drops whenever the queue holds two samples. A stalled
// receiver holds the engine on its finished result, so the queue fills
// and the input stalls. From sample beat to update beat the engine does a
// store read, two products on one multiplier, a sum, a restoring divide,
// a clamp and the write-back; an unknown voxel skips the arithmetic.
// Samples are processed one at a time: the next starts only when the last
// is done. After reset the store is swept to 1.0 / weight 0, one voxel a
// cycle, over all 65536 voxels; 'sample.ready' stays low until the sweep
// ends.
// ----------------------------------------------------------------------------
module tsdf_voxel_fusion
(
    input  logic                            clk,
    input  logic                            rst_n,
    tvf_sample_if.sink                      sample,
    tvf_update_if.source                    update,
    input  logic                            cfg_write_enable,
    input  logic [tvf_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [tvf_pkg::CFG_W-1:0]       cfg_data
);

    logic [tvf_pkg::TRUNC_W-1:0] trunc_reg;
    logic [tvf_pkg::EPS_W-1:0]   eps_reg;
    tvf_pkg::tvf_status_t        status;
    tvf_pkg::tvf_entry_t         head;
    logic                        head_valid;
    logic                        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trunc_reg <= tvf_pkg::TRUNC_RESET;
            eps_reg   <= tvf_pkg::EPS_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                tvf_pkg::CFG_TRUNC: trunc_reg <= cfg_data[tvf_pkg::TRUNC_W-1:0];
                tvf_pkg::CFG_EPS:   eps_reg   <= cfg_data[tvf_pkg::EPS_W-1:0];
            endcase
        end
    end

    tvf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .status     (status),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tvf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .trunc      (trunc_reg),
        .eps        (eps_reg),
        .status     (status),
        .update     (update)
    );

endmodule

/* dv/tsdf_voxel_fusion_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf_voxel_fusion_tb
// Self-checking bench for the TSDF voxel fusion block.
//
// Holds its own copy of the voxel store and of the two configuration
// registers. Each accepted sample is fused into that copy, and the updated
// voxel is queued. Each update beat from the block is then compared, field
// by field, with the oldest queued update. Directed cases cover unknown
// voxels, field extremes, saturation, rounding toward zero and the extreme
// register settings. One long receiver hold-off then backs the block up
// into its input. Random phases with hot voxel pools follow, run under
// several settings and several idle and stall mixes.
// ----------------------------------------------------------------------------
module tsdf_voxel_fusion_tb;

    typedef struct packed {
        logic [tvf_pkg::ADDR_W-1:0]        addr;
        logic signed [tvf_pkg::DIST_W-1:0] distance;
        logic [tvf_pkg::WT_W-1:0]          wt;
        logic                              unknown;
    } fused_voxel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                       cfg_write_enable;
    logic [tvf_pkg::CFG_IW-1:0] cfg_index;
    logic [tvf_pkg::CFG_W-1:0]  cfg_data;

    tvf_sample_if sample_ch ();
    tvf_update_if update_ch ();

    tsdf_voxel_fusion dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (sample_ch),
        .update           (update_ch),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Local copy of the voxel store and registers
    logic signed [tvf_pkg::DIST_W-1:0] stored_distance [tvf_pkg::MAP_VOXELS];
    logic [tvf_pkg::WT_W-1:0]          stored_weight   [tvf_pkg::MAP_VOXELS];
    logic [tvf_pkg::TRUNC_W-1:0]       trunc_limit;
    logic [tvf_pkg::EPS_W-1:0]         eps_limit;

    fused_voxel_t expected_updates [$];
    fused_voxel_t seen_update;
    fused_voxel_t want_update;
    int           mismatch_count = 0;

    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    logic         hold_requested = 1'b0;
    int           hold_len       = 0;
    int           hold_left      = 0;

    logic [tvf_pkg::ADDR_W-1:0] hot_voxels [16];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("tsdf_voxel_fusion_tb: done, errors");
        $finish;
    end

    function automatic fused_voxel_t fuse_voxel(
        input logic [tvf_pkg::ADDR_W-1:0] addr,
        input logic signed [tvf_pkg::DIST_W-1:0] d,
        input logic [tvf_pkg::WT_W-1:0] w);
        fused_voxel_t upd;
        longint       old_wt;
        longint       old_dist;
        longint       sum_wt;
        longint       num;
        longint       q;
        longint       t;
        old_wt   = stored_weight[addr];
        old_dist = stored_distance[addr];
        sum_wt   = old_wt + longint'(w);
        upd.addr = addr;
        if (sum_wt < longint'(eps_limit) || sum_wt == 0)
        begin
            stored_distance[addr] = tvf_pkg::ONE_Q12;
            stored_weight[addr]   = '0;
            upd.distance = tvf_pkg::ONE_Q12;
            upd.wt       = '0;
            upd.unknown  = 1'b1;
        end
        else
        begin
            // an unobserved voxel carries no distance into the average
            if (old_wt < longint'(eps_limit))
                old_dist = 0;
            num = old_dist * old_wt + longint'(d) * longint'(w);
            q   = num / sum_wt;
            t   = longint'(trunc_limit);
            if (q > 0)
            begin
                if (q > t)
                    q = t;
            end
            else if (q < -t)
                q = -t;
            if (sum_wt > longint'(tvf_pkg::WEIGHT_MAX))
                sum_wt = longint'(tvf_pkg::WEIGHT_MAX);
            upd.distance = q[tvf_pkg::DIST_W-1:0];
            upd.wt       = sum_wt[tvf_pkg::WT_W-1:0];
            upd.unknown  = 1'b0;
            stored_distance[addr] = upd.distance;
            stored_weight[addr]   = upd.wt;
        end
        return upd;
    endfunction

    task automatic send_sample(input logic [tvf_pkg::ADDR_W-1:0] addr,
                               input logic signed [tvf_pkg::DIST_W-1:0] d,
                               input logic [tvf_pkg::WT_W-1:0] w);
        fused_voxel_t accepted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid           <= 1'b1;
        sample_ch.voxel_address   <= addr;
        sample_ch.sample_distance <= d;
        sample_ch.sample_weight   <= w;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        accepted         = fuse_voxel(addr, d, w);
        expected_updates = {expected_updates, accepted};
    endtask

    task automatic drain_updates();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [tvf_pkg::CFG_IW-1:0] index,
                                  input logic [tvf_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= index;
        cfg_data         <= value;
        @(posedge clk);
        if (index == tvf_pkg::CFG_TRUNC)
            trunc_limit = value[tvf_pkg::TRUNC_W-1:0];
        else
            eps_limit = value[tvf_pkg::EPS_W-1:0];
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic set_fusion_config(input logic [tvf_pkg::TRUNC_W-1:0] trunc,
                                     input logic [tvf_pkg::EPS_W-1:0] eps);
        drain_updates();
        write_register(tvf_pkg::CFG_TRUNC, tvf_pkg::CFG_W'(trunc));
        write_register(tvf_pkg::CFG_EPS, eps);
    endtask

    function automatic logic [tvf_pkg::ADDR_W-1:0] random_address();
        if ($urandom_range(3) != 0)
            return hot_voxels[$urandom_range(15)];
        return tvf_pkg::ADDR_W'($urandom);
    endfunction

    function automatic logic signed [tvf_pkg::DIST_W-1:0] random_distance();
        int span;
        span = int'(trunc_limit) + 100;
        if ($urandom_range(1) != 0)
            return tvf_pkg::DIST_W'($urandom);
        return tvf_pkg::DIST_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [tvf_pkg::WT_W-1:0] random_weight();
        case ($urandom_range(9)) inside
            0:       return '0;
            [1:2]:   return tvf_pkg::WT_W'($urandom_range(0, eps_limit + 8));
            [3:6]:   return tvf_pkg::WT_W'($urandom_range(1, 1 << 18));
            7:       return tvf_pkg::WT_W'($urandom_range(1 << 20, tvf_pkg::WEIGHT_MAX));
            8:       return tvf_pkg::WT_W'($urandom);
            default: return ($urandom_range(1) != 0) ? tvf_pkg::WEIGHT_MAX : '1;
        endcase
    endfunction

    task automatic check_unknown_voxels();
        send_sample(16'd0, 16'sd0, 30'd0);
        send_sample(16'd1, 16'sh7FFF, 30'd6);
        send_sample(16'd2, -16'sd32768, 30'd7);
        send_sample(16'd4, 16'sd0, 30'd1);
    endtask

    task automatic check_fusion_extremes();
        send_sample(16'd3, 16'sh7FFF, 30'd65536);
        send_sample(16'd3, -16'sd32768, 30'd65536);
        send_sample(16'hFFFF, -16'sd1, 30'h3FFF_FFFF);
        send_sample(16'hFFFF, 16'sd100, 30'h3FFF_FFFF);
        send_sample(16'hAAAA, 16'sh5555, 30'h2AAA_AAAA);
        send_sample(16'h5555, 16'shAAAA, 30'h1555_5555);
        send_sample(16'd4, 16'sd0, 30'd100);
        // quotients that must round toward zero on both sides
        send_sample(16'd5, 16'sd10, 30'd100);
        send_sample(16'd5, -16'sd3, 30'd200);
        send_sample(16'd5, -16'sd30, 30'd200);
    endtask

    task automatic check_config_extremes();
        set_fusion_config(15'd0, 16'd0);
        send_sample(16'd6, 16'sd0, 30'd0);
        send_sample(16'd6, 16'sd1000, 30'd1);
        send_sample(16'd7, -16'sd1000, 30'd5);
        set_fusion_config(15'h7FFF, 16'hFFFF);
        send_sample(16'd3, 16'sd1234, 30'd100);
        send_sample(16'd8, 16'sh7FFF, 30'd65534);
        send_sample(16'd8, 16'sh7FFF, 30'd65535);
        send_sample(16'd9, -16'sd32768, 30'd65535);
        send_sample(16'd9, 16'sd77, 30'd1);
    endtask

    task automatic check_random_fusion(input int idle_pct, input int stall_pct,
                                       input logic [tvf_pkg::TRUNC_W-1:0] trunc,
                                       input logic [tvf_pkg::EPS_W-1:0] eps,
                                       input int count);
        int n;
        set_fusion_config(trunc, eps);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hot_voxels[0]  = '0;
        hot_voxels[1]  = '1;
        for (n = 2; n < 16; n++)
            hot_voxels[n] = tvf_pkg::ADDR_W'($urandom);
        for (n = 0; n < count; n++)
            send_sample(random_address(), random_distance(), random_weight());
    endtask

    task automatic check_backpressure();
        int n;
        set_fusion_config(15'd819, 16'd7);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // the receiver process counts this stretch down on its own
        hold_len       = 400;
        hold_requested = 1'b1;
        for (n = 0; n < 40; n++)
            send_sample(16'(n % 5), random_distance(), random_weight());
    endtask

    // Receiver: ready changes on the falling edge only
    initial
    begin
        update_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requested)
            begin
                hold_left      = hold_len;
                hold_requested = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                update_ch.ready <= 1'b0;
            end
            else
                update_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && update_ch.valid === 1'b1 && update_ch.ready === 1'b1)
        begin
            seen_update = '{addr: update_ch.updated_address,
                            distance: update_ch.updated_distance,
                            wt: update_ch.updated_weight,
                            unknown: update_ch.became_unknown};
            if (expected_updates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected update beat: addr %h dist %0d wt %0d unknown %b",
                             seen_update.addr, seen_update.distance, seen_update.wt,
                             seen_update.unknown);
            end
            else
            begin
                want_update = expected_updates.pop_front();
                if (seen_update !== want_update)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"update mismatch: exp addr %h dist %0d wt %0d unknown %b,",
                                  " got addr %h dist %0d wt %0d unknown %b"},
                                 want_update.addr, want_update.distance, want_update.wt,
                                 want_update.unknown, seen_update.addr,
                                 seen_update.distance, seen_update.wt,
                                 seen_update.unknown);
                end
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < tvf_pkg::MAP_VOXELS; i++)
        begin
            stored_distance[i] = tvf_pkg::ONE_Q12;
            stored_weight[i]   = '0;
        end
        trunc_limit               = tvf_pkg::TRUNC_RESET;
        eps_limit                 = tvf_pkg::EPS_RESET;
        rst_n                     = 1'b0;
        cfg_write_enable          = 1'b0;
        cfg_index                 = '0;
        cfg_data                  = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.voxel_address   = '0;
        sample_ch.sample_distance = '0;
        sample_ch.sample_weight   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_unknown_voxels();
        check_fusion_extremes();
        check_config_extremes();
        check_backpressure();
        check_random_fusion(0, 0, 15'd819, 16'd7, 330);
        check_random_fusion(88, 0, tvf_pkg::TRUNC_W'($urandom_range(0, 32767)),
                            tvf_pkg::EPS_W'($urandom_range(0, 64)), 330);
        check_random_fusion(0, 88, 15'h7FFF, 16'd0, 330);
        check_random_fusion(29, 29, tvf_pkg::TRUNC_W'($urandom_range(0, 32767)),
                            tvf_pkg::EPS_W'($urandom_range(0, 65535)), 330);

        drain_updates();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_updates.size() == 0)
            $display("tsdf_voxel_fusion_tb: done, clean");
        else
            $display("tsdf_voxel_fusion_tb: done, errors");
        $finish;
    end

endmodule
